[design/fpw_pkg.sv]
// Shared types, constants and the channel packing function for the
// framebuffer pixel writer. No dependencies; every other design file imports it.
`default_nettype none

package fpw_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int ADDR_W         = 32;
  localparam int WORD_W         = 32;
  localparam int COLOUR_W       = 24;
  localparam int CHAN_W         = 8;
  localparam int DIM_W          = 14;
  localparam int PITCH_W        = 16;
  localparam int LAYOUT_W       = 9;
  localparam int MODE_W         = 2;
  localparam int POS_W          = 5;
  localparam int SIZE_W         = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF   = 2'd0,
    MODE_RGB24 = 2'd1,
    MODE_RGB32 = 2'd2
  } pixel_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_MODE     = 3'd0,
    CFG_FB_BASE        = 3'd1,
    CFG_LINE_PITCH     = 3'd2,
    CFG_SURFACE_WIDTH  = 3'd3,
    CFG_SURFACE_HEIGHT = 3'd4,
    CFG_RED_LAYOUT     = 3'd5,
    CFG_GREEN_LAYOUT   = 3'd6,
    CFG_BLUE_LAYOUT    = 3'd7
  } cfg_reg_e;

  localparam logic [LAYOUT_W-1:0] RED_LAYOUT_RST   = 9'd272;
  localparam logic [LAYOUT_W-1:0] GREEN_LAYOUT_RST = 9'd264;
  localparam logic [LAYOUT_W-1:0] BLUE_LAYOUT_RST  = 9'd256;

  typedef struct packed {
    logic [MODE_W-1:0]   pixel_mode;
    logic [ADDR_W-1:0]   fb_base;
    logic [PITCH_W-1:0]  line_pitch;
    logic [DIM_W-1:0]    surface_width;
    logic [DIM_W-1:0]    surface_height;
    logic [LAYOUT_W-1:0] red_layout;
    logic [LAYOUT_W-1:0] green_layout;
    logic [LAYOUT_W-1:0] blue_layout;
  } cfg_t;

  // Keeps the top 'size' bits of the channel (size saturates at the channel
  // width) and places them at bit 'pos'; bits pushed past the word are lost.
  function automatic logic [WORD_W-1:0] pack_channel(input logic [CHAN_W-1:0]   chan,
                                                     input logic [LAYOUT_W-1:0] layout);
    logic [POS_W-1:0]  pos;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] drop;
    logic [CHAN_W-1:0] kept;
    pos  = layout[POS_W-1:0];
    size = layout[LAYOUT_W-1:POS_W];
    if (size > SIZE_W'(CHAN_W)) size = SIZE_W'(CHAN_W);
    drop = SIZE_W'(CHAN_W) - size;
    kept = chan >> drop;
    return WORD_W'(kept) << pos;
  endfunction

endpackage

`default_nettype wire

[design/fpw_req_if.sv]
// Request channel of the pixel writer: valid/ready plus position and colour.
// Depends on fpw_pkg for widths.
`default_nettype none

interface fpw_req_if #(
  parameter int COORD_BITS = fpw_pkg::COORD_BITS_DEF
) ();
  import fpw_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic [COLOUR_W-1:0]          rgb_colour;

  modport source (output valid, pos_x, pos_y, rgb_colour, input ready);
  modport sink   (input valid, pos_x, pos_y, rgb_colour, output ready);
endinterface

`default_nettype wire

[design/fpw_wr_if.sv]
// Memory write channel of the pixel writer: valid/ready plus address, data, size.
// Depends on fpw_pkg for widths.
`default_nettype none

interface fpw_wr_if ();
  import fpw_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] byte_address;
  logic [WORD_W-1:0] pixel_word;
  logic              four_bytes;

  modport source (output valid, byte_address, pixel_word, four_bytes, input ready);
  modport sink   (input valid, byte_address, pixel_word, four_bytes, output ready);
endinterface

`default_nettype wire

[design/fpw_cfg_regs.sv]
// Configuration register file of the pixel writer, written through a plain
// index/data port. Depends on fpw_pkg.
`default_nettype none

module fpw_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fpw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpw_pkg::CFG_DATA_W-1:0]  cfg_data,
  output fpw_pkg::cfg_t                   cfg
);
  import fpw_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_mode     <= MODE_OFF;
      cfg.fb_base        <= '0;
      cfg.line_pitch     <= '0;
      cfg.surface_width  <= '0;
      cfg.surface_height <= '0;
      cfg.red_layout     <= RED_LAYOUT_RST;
      cfg.green_layout   <= GREEN_LAYOUT_RST;
      cfg.blue_layout    <= BLUE_LAYOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_MODE:     cfg.pixel_mode     <= cfg_data[MODE_W-1:0];
        CFG_FB_BASE:        cfg.fb_base        <= cfg_data[ADDR_W-1:0];
        CFG_LINE_PITCH:     cfg.line_pitch     <= cfg_data[PITCH_W-1:0];
        CFG_SURFACE_WIDTH:  cfg.surface_width  <= cfg_data[DIM_W-1:0];
        CFG_SURFACE_HEIGHT: cfg.surface_height <= cfg_data[DIM_W-1:0];
        CFG_RED_LAYOUT:     cfg.red_layout     <= cfg_data[LAYOUT_W-1:0];
        CFG_GREEN_LAYOUT:   cfg.green_layout   <= cfg_data[LAYOUT_W-1:0];
        CFG_BLUE_LAYOUT:    cfg.blue_layout    <= cfg_data[LAYOUT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/fpw_pixel_calc.sv]
// Combinational pixel datapath: clipping, byte address and pixel packing.
// Depends on fpw_pkg; sits between the request and result registers.
`default_nettype none

module fpw_pixel_calc #(
  parameter int COORD_BITS = fpw_pkg::COORD_BITS_DEF
) (
  input  fpw_pkg::cfg_t                    cfg,
  input  logic signed [COORD_BITS-1:0]     pos_x,
  input  logic signed [COORD_BITS-1:0]     pos_y,
  input  logic [fpw_pkg::COLOUR_W-1:0]     rgb_colour,
  output logic                             keep,
  output logic [fpw_pkg::ADDR_W-1:0]       byte_address,
  output logic [fpw_pkg::WORD_W-1:0]       pixel_word,
  output logic                             four_bytes
);
  import fpw_pkg::*;

  localparam int CMP_W  = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;
  localparam int PROD_W = COORD_BITS + PITCH_W;

  logic              mode_on;
  logic              negative;
  logic              in_bounds;
  logic [PROD_W-1:0] row_offset;
  logic [ADDR_W-1:0] x_addr;
  logic [ADDR_W-1:0] col_offset;

  assign mode_on    = (cfg.pixel_mode == MODE_RGB24) || (cfg.pixel_mode == MODE_RGB32);
  assign four_bytes = (cfg.pixel_mode == MODE_RGB32);
  assign negative   = pos_x[COORD_BITS-1] | pos_y[COORD_BITS-1];
  assign in_bounds  = (CMP_W'($unsigned(pos_x)) < CMP_W'(cfg.surface_width)) &&
                      (CMP_W'($unsigned(pos_y)) < CMP_W'(cfg.surface_height));
  assign keep       = mode_on && !negative && in_bounds;

  // Only the low address bits matter, so everything wraps at the address width.
  assign row_offset   = $unsigned(pos_y) * cfg.line_pitch;
  assign x_addr       = ADDR_W'($unsigned(pos_x));
  assign col_offset   = four_bytes ? (x_addr << 2) : (x_addr + (x_addr << 1));
  assign byte_address = cfg.fb_base + ADDR_W'(row_offset) + col_offset;

  assign pixel_word = pack_channel(rgb_colour[3*CHAN_W-1:2*CHAN_W], cfg.red_layout)
                    | pack_channel(rgb_colour[2*CHAN_W-1:CHAN_W],   cfg.green_layout)
                    | pack_channel(rgb_colour[CHAN_W-1:0],          cfg.blue_layout);

endmodule

`default_nettype wire

[design/framebuffer_pixel_writer_core.sv]
// Framebuffer pixel writer: one request register, one result register.
// Throughput: one request per cycle unless a stalled write holds a kept request in the
// request register, which refills in the cycle it empties.
// Clipped requests and requests in disabled mode leave no write.
// Reset (synchronous, active high) empties both stages and loads register defaults.
// Depends on fpw_pkg, fpw_req_if, fpw_wr_if, fpw_cfg_regs and fpw_pixel_calc.
`default_nettype none

module framebuffer_pixel_writer_core #(
  parameter int COORD_BITS = fpw_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  fpw_req_if.sink                        req,
  fpw_wr_if.source                       wr,
  input  logic                           cfg_we,
  input  logic [fpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fpw_pkg::*;

  cfg_t                         cfg;

  logic                         s1_valid;
  logic signed [COORD_BITS-1:0] s1_x;
  logic signed [COORD_BITS-1:0] s1_y;
  logic [COLOUR_W-1:0]          s1_rgb;

  logic                         calc_keep;
  logic [ADDR_W-1:0]            calc_addr;
  logic [WORD_W-1:0]            calc_word;
  logic                         calc_four;

  logic                         out_valid;
  logic [ADDR_W-1:0]            out_addr;
  logic [WORD_W-1:0]            out_word;
  logic                         out_four;

  logic                         out_free;
  logic                         s1_adv;

  fpw_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fpw_pixel_calc #(
    .COORD_BITS (COORD_BITS)
  ) u_pixel_calc (
    .cfg          (cfg),
    .pos_x        (s1_x),
    .pos_y        (s1_y),
    .rgb_colour   (s1_rgb),
    .keep         (calc_keep),
    .byte_address (calc_addr),
    .pixel_word   (calc_word),
    .four_bytes   (calc_four)
  );

  // A dropped request leaves the first stage without needing the result register.
  assign out_free  = !out_valid || wr.ready;
  assign s1_adv    = s1_valid && (!calc_keep || out_free);
  assign req.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_x   <= req.pos_x;
      s1_y   <= req.pos_y;
      s1_rgb <= req.rgb_colour;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && calc_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid && calc_keep) begin
      out_addr <= calc_addr;
      out_word <= calc_word;
      out_four <= calc_four;
    end
  end

  assign wr.valid        = out_valid;
  assign wr.byte_address = out_addr;
  assign wr.pixel_word   = out_word;
  assign wr.four_bytes   = out_four;

`ifndef SYNTH
  a_kept_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && calc_keep) |=> out_valid)
    else $error("kept request did not reach the result register");

  a_no_overwrite_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !wr.ready) |-> !(s1_adv && calc_keep))
    else $error("stalled result would be overwritten");

  a_accept_needs_room: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> (!s1_valid || s1_adv))
    else $error("request accepted while the first stage is held");
`endif

endmodule

`default_nettype wire

[tb/tb_framebuffer_pixel_writer_core.sv]
// Self-checking testbench for framebuffer_pixel_writer_core: queue-fed request driver,
// write monitor with a built-in pixel address and packing predictor, register reprogramming.
// Depends on fpw_pkg, fpw_req_if, fpw_wr_if and the core itself.

module tb_framebuffer_pixel_writer_core;
  import fpw_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [COLOUR_W-1:0]  colour;
  } draw_req_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
    logic              four;
  } mem_write_t;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fpw_req_if #(.COORD_BITS(CW)) req ();
  fpw_wr_if                     wr ();

  framebuffer_pixel_writer_core #(.COORD_BITS(CW)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .wr        (wr),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  draw_req_t  pending_draws[$];
  mem_write_t expected_writes[$];
  cfg_t       shadow_cfg;
  int         send_idle_pct;
  int         stall_pct;
  int         errors;
  int         cycles;
  bit         req_taken;
  draw_req_t  next_draw;
  draw_req_t  taken_draw;
  mem_write_t predicted;
  mem_write_t want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Keeps the top bits of one colour channel and moves them to their field position.
  function automatic logic [WORD_W-1:0] place_channel(input logic [CHAN_W-1:0] chan,
                                                      input logic [LAYOUT_W-1:0] layout);
    int unsigned keep;
    logic [63:0] v;
    keep = layout[LAYOUT_W-1:POS_W];
    if (keep > CHAN_W) keep = CHAN_W;
    v = 64'(chan >> (CHAN_W - keep));
    v = v << layout[POS_W-1:0];
    return v[WORD_W-1:0];
  endfunction

  function automatic bit predict_write(input draw_req_t d, input cfg_t c,
                                       output mem_write_t w);
    logic [63:0] addr;
    int unsigned bpp;
    w = '{addr: '0, word: '0, four: 1'b0};
    if (c.pixel_mode != MODE_RGB24 && c.pixel_mode != MODE_RGB32) return 1'b0;
    if (d.x < 0 || d.y < 0) return 1'b0;
    if (int'(d.x) >= int'(c.surface_width) || int'(d.y) >= int'(c.surface_height))
      return 1'b0;
    bpp = (c.pixel_mode == MODE_RGB32) ? 4 : 3;
    addr = 64'(c.fb_base) + 64'(d.y) * 64'(c.line_pitch) + 64'(d.x) * 64'(bpp);
    w.addr = addr[ADDR_W-1:0];
    w.word = place_channel(d.colour[23:16], c.red_layout)
           | place_channel(d.colour[15:8], c.green_layout)
           | place_channel(d.colour[7:0], c.blue_layout);
    w.four = (c.pixel_mode == MODE_RGB32);
    return 1'b1;
  endfunction

  // Request driver: a held request stays on the bus until the edge that takes it.
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      if (pending_draws.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_draw = pending_draws.pop_front();
        req.valid      <= 1'b1;
        req.pos_x      <= next_draw.x;
        req.pos_y      <= next_draw.y;
        req.rgb_colour <= next_draw.colour;
      end else begin
        req.valid <= 1'b0;
      end
    end
    wr.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: checks each write transaction, predicts from each request transaction
  // and mirrors register writes.
  always @(posedge clk) begin
    if (rst) begin
      shadow_cfg.pixel_mode     = MODE_OFF;
      shadow_cfg.fb_base        = '0;
      shadow_cfg.line_pitch     = '0;
      shadow_cfg.surface_width  = '0;
      shadow_cfg.surface_height = '0;
      shadow_cfg.red_layout     = RED_LAYOUT_RST;
      shadow_cfg.green_layout   = GREEN_LAYOUT_RST;
      shadow_cfg.blue_layout    = BLUE_LAYOUT_RST;
      req_taken = 1'b0;
    end else begin
      if (wr.valid && wr.ready) begin
        if (expected_writes.size() == 0) begin
          errors++;
          $display("%0t: write with none expected: addr=%h data=%h four=%b",
                   $time, wr.byte_address, wr.pixel_word, wr.four_bytes);
        end else begin
          want = expected_writes.pop_front();
          if (wr.byte_address !== want.addr || wr.pixel_word !== want.word ||
              wr.four_bytes !== want.four) begin
            errors++;
            $display("%0t: expected addr=%h data=%h four=%b, got addr=%h data=%h four=%b",
                     $time, want.addr, want.word, want.four,
                     wr.byte_address, wr.pixel_word, wr.four_bytes);
          end
        end
      end
      req_taken = req.valid && req.ready;
      if (req_taken) begin
        taken_draw.x      = req.pos_x;
        taken_draw.y      = req.pos_y;
        taken_draw.colour = req.rgb_colour;
        if (predict_write(taken_draw, shadow_cfg, predicted))
          expected_writes.push_back(predicted);
      end
      if (cfg_we) begin
        case (cfg_reg_e'(cfg_index))
          CFG_PIXEL_MODE:     shadow_cfg.pixel_mode     = cfg_data[MODE_W-1:0];
          CFG_FB_BASE:        shadow_cfg.fb_base        = cfg_data[ADDR_W-1:0];
          CFG_LINE_PITCH:     shadow_cfg.line_pitch     = cfg_data[PITCH_W-1:0];
          CFG_SURFACE_WIDTH:  shadow_cfg.surface_width  = cfg_data[DIM_W-1:0];
          CFG_SURFACE_HEIGHT: shadow_cfg.surface_height = cfg_data[DIM_W-1:0];
          CFG_RED_LAYOUT:     shadow_cfg.red_layout     = cfg_data[LAYOUT_W-1:0];
          CFG_GREEN_LAYOUT:   shadow_cfg.green_layout   = cfg_data[LAYOUT_W-1:0];
          CFG_BLUE_LAYOUT:    shadow_cfg.blue_layout    = cfg_data[LAYOUT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_framebuffer_pixel_writer_core failed");
      $finish;
    end
  end

  task automatic settle();
    while (pending_draws.size() != 0 || req.valid || expected_writes.size() != 0)
      @(posedge clk);
  endtask

  // Dropped requests can still sit in the pipeline after the last write has come.
  task automatic drain();
    settle();
    repeat (4) @(posedge clk);
  endtask

  // Bits above the register width are sometimes filled with junk; the core must drop them.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val,
                           input int width);
    logic [CFG_DATA_W-1:0] data;
    data = val;
    if (width < CFG_DATA_W && $urandom_range(1) == 1)
      data = data | (($urandom() >> width) << width);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic apply_setup(input cfg_t c);
    @(negedge clk);
    write_reg(CFG_PIXEL_MODE, CFG_DATA_W'(c.pixel_mode), MODE_W);
    write_reg(CFG_FB_BASE, c.fb_base, ADDR_W);
    write_reg(CFG_LINE_PITCH, CFG_DATA_W'(c.line_pitch), PITCH_W);
    write_reg(CFG_SURFACE_WIDTH, CFG_DATA_W'(c.surface_width), DIM_W);
    write_reg(CFG_SURFACE_HEIGHT, CFG_DATA_W'(c.surface_height), DIM_W);
    write_reg(CFG_RED_LAYOUT, CFG_DATA_W'(c.red_layout), LAYOUT_W);
    write_reg(CFG_GREEN_LAYOUT, CFG_DATA_W'(c.green_layout), LAYOUT_W);
    write_reg(CFG_BLUE_LAYOUT, CFG_DATA_W'(c.blue_layout), LAYOUT_W);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cfg_t make_cfg(input logic [MODE_W-1:0] mode,
                                    input logic [ADDR_W-1:0] base,
                                    input logic [PITCH_W-1:0] pitch,
                                    input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                    input logic [LAYOUT_W-1:0] r,
                                    input logic [LAYOUT_W-1:0] g,
                                    input logic [LAYOUT_W-1:0] b);
    cfg_t c;
    c.pixel_mode     = mode;
    c.fb_base        = base;
    c.line_pitch     = pitch;
    c.surface_width  = w;
    c.surface_height = h;
    c.red_layout     = r;
    c.green_layout   = g;
    c.blue_layout    = b;
    return c;
  endfunction

  task automatic add_draw(input int x, input int y, input logic [COLOUR_W-1:0] colour);
    draw_req_t d;
    d.x = CW'(x);
    d.y = CW'(y);
    d.colour = colour;
    pending_draws.push_back(d);
  endtask

  // Mostly points near the visible surface, so both the clip edge and the inside get hit.
  function automatic int pick_coord(input int lim);
    if ($urandom_range(99) < 22) return int'($urandom());
    return $urandom_range(0, (lim + 3 > 32767) ? 32767 : lim + 3);
  endfunction

  task automatic run_phase(input int k);
    cfg_t c;
    logic [MODE_W-1:0] mode;
    int n;
    case (k % 7)
      5:       mode = MODE_OFF;
      6:       mode = MODE_RESERVED;
      default: mode = (k % 2 == 1) ? MODE_RGB24 : MODE_RGB32;
    endcase
    c = make_cfg(mode, $urandom(), 16'($urandom()), 14'($urandom_range(1, 60)),
                 14'($urandom_range(1, 60)), 9'($urandom()), 9'($urandom()),
                 9'($urandom()));
    if (k == 0) begin
      c.fb_base    = '1;
      c.line_pitch = '1;
    end else if (k == 1) begin
      c.fb_base    = '0;
      c.line_pitch = '0;
    end
    if (k == 2) begin
      c.surface_width  = 14'd8192;
      c.surface_height = 14'd8192;
      c.red_layout     = '1;
      c.green_layout   = '1;
      c.blue_layout    = '1;
    end else if (k == 3) begin
      c.surface_width  = 14'd1;
      c.surface_height = 14'd1;
      c.red_layout     = '0;
      c.green_layout   = '0;
      c.blue_layout    = '0;
    end else if (k == 4) begin
      c.red_layout   = RED_LAYOUT_RST;
      c.green_layout = GREEN_LAYOUT_RST;
      c.blue_layout  = BLUE_LAYOUT_RST;
    end else if (k == 8) begin
      c.surface_width  = 14'($urandom());
      c.surface_height = 14'($urandom());
    end
    n = (mode == MODE_RGB24 || mode == MODE_RGB32) ? 170 : 40;
    drain();
    apply_setup(c);
    case (k % 5)
      1:       begin send_idle_pct = 71; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 71; end
      3:       begin send_idle_pct = 32; stall_pct = 32; end
      default: begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
    for (int i = 0; i < n; i++) begin
      // Halfway through, the sender holds off until every write has come back.
      if (i == n / 2) settle();
      add_draw(pick_coord(c.surface_width), pick_coord(c.surface_height), 24'($urandom()));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.pos_x = '0;
    req.pos_y = '0;
    req.rgb_colour = '0;
    wr.ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    errors = 0;
    cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full surface near the top of the address space: corners, clip edges, wraparound.
    apply_setup(make_cfg(MODE_RGB32, 32'hFFFF_FF00, 16'hFFFF, 14'd8192, 14'd8192,
                         RED_LAYOUT_RST, GREEN_LAYOUT_RST, BLUE_LAYOUT_RST));
    add_draw(0, 0, 24'h000000);
    add_draw(8191, 8191, 24'hFFFFFF);
    add_draw(8192, 0, 24'h123456);
    add_draw(0, 8192, 24'h654321);
    add_draw(-1, 0, 24'hFFFFFF);
    add_draw(0, -1, 24'hFFFFFF);
    add_draw(-32768, -32768, 24'hAAAAAA);
    add_draw(32767, 32767, 24'h555555);
    add_draw(100, 200, 24'hA5C3E1);
    drain();

    // Three-byte pixels; red pushed partly past bit 31, green of size zero, blue oversized.
    apply_setup(make_cfg(MODE_RGB24, 32'h0000_1000, 16'h0780, 14'd640, 14'd480,
                         9'((8 << POS_W) | 28), 9'(5), 9'(12 << POS_W)));
    add_draw(639, 479, 24'hFFFFFF);
    add_draw(640, 0, 24'hFFFFFF);
    add_draw(3, 4, 24'h123456);
    add_draw(0, 0, 24'h800001);
    drain();

    // The reserved mode behaves like the disabled one.
    apply_setup(make_cfg(MODE_RESERVED, 32'h0, 16'h10, 14'd8192, 14'd8192,
                         RED_LAYOUT_RST, GREEN_LAYOUT_RST, BLUE_LAYOUT_RST));
    add_draw(1, 1, 24'h010203);
    add_draw(2, 2, 24'h040506);
    drain();

    // An empty surface clips everything.
    apply_setup(make_cfg(MODE_RGB32, 32'h0, 16'h10, 14'd0, 14'd100,
                         RED_LAYOUT_RST, GREEN_LAYOUT_RST, BLUE_LAYOUT_RST));
    add_draw(0, 0, 24'hFFFFFF);
    add_draw(5, 5, 24'hFFFFFF);
    drain();
    apply_setup(make_cfg(MODE_RGB32, 32'h0, 16'h10, 14'd100, 14'd0,
                         RED_LAYOUT_RST, GREEN_LAYOUT_RST, BLUE_LAYOUT_RST));
    add_draw(0, 0, 24'hFFFFFF);
    add_draw(5, 5, 24'hFFFFFF);

    for (int k = 0; k < 14; k++) run_phase(k);

    drain();
    repeat (10) @(posedge clk);
    if (expected_writes.size() != 0) begin
      errors += expected_writes.size();
      $display("%0t: %0d expected writes never arrived", $time, expected_writes.size());
    end
    if (errors == 0) begin
      $display("tb_framebuffer_pixel_writer_core passed");
    end else begin
      $display("tb_framebuffer_pixel_writer_core failed");
    end
    $finish;
  end

endmodule
